### rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the transaction payload structs, action codes and character constants.
// No dependencies.
package tcw_pkg;

  // Action codes carried in the input transaction.
  localparam logic [2:0] ACT_PUT       = 3'd0;
  localparam logic [2:0] ACT_NEWLINE   = 3'd1;
  localparam logic [2:0] ACT_BACKSPACE = 3'd2;
  localparam logic [2:0] ACT_CLEAR     = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;

  // Character and attribute constants.
  localparam logic [7:0] CHAR_NULL    = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_BLANK   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  character;
    logic [10:0] cell_index;
  } tcw_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [7:0]  read_character;
    logic [7:0]  read_attribute;
  } tcw_out_t;

endpackage

### rtl/tcw_screen_ram.sv
// Screen store: one write port and one registered read port.
// Each entry holds an attribute byte over a character byte.
// No dependencies.
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  // Write when enabled; registered read every cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tcw_ctrl.sv
// Sequencer of the text console writer: cursor, attribute register and the
// shared address counter that walks the screen store for scroll and fill.
// Depends on tcw_pkg; drives the ports of tcw_screen_ram.
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tcw_in_t                           in_data,
  input  logic                              cfg_wr_en,
  input  logic [7:0]                        cfg_wr_data,
  output logic                              res_valid,
  input  logic                              res_take,
  output tcw_out_t                          res_data,
  output logic                              mem_wr_en,
  output logic [$clog2(COLUMNS*ROWS)-1:0]   mem_wr_addr,
  output logic [15:0]                       mem_wr_data,
  output logic [$clog2(COLUMNS*ROWS)-1:0]   mem_rd_addr,
  input  logic [15:0]                       mem_rd_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + COLUMNS + 1);
  localparam int COLW  = $clog2(COLUMNS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUT   = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_RDATA = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      ret_r, ret_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;
  logic            pv_r, pv_nxt;
  logic [7:0]      fill_attr_r, fill_attr_nxt;
  logic [7:0]      attr_r, attr_nxt;
  logic [7:0]      chr_r, chr_nxt;
  logic [10:0]     idx_r, idx_nxt;
  logic [7:0]      rch_r, rch_nxt;
  logic [7:0]      rattr_r, rattr_nxt;

  logic            accept;
  logic            past_end;
  logic [CW-1:0]   row_next;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign past_end = (cursor_r >= CW'(CELLS));
  assign row_next = cursor_r - CW'(col_r) + CW'(COLUMNS);

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    wa_nxt        = wa_r;
    pv_nxt        = pv_r;
    fill_attr_nxt = fill_attr_r;
    attr_nxt      = cfg_wr_en ? cfg_wr_data : attr_r;
    chr_nxt       = chr_r;
    idx_nxt       = idx_r;
    rch_nxt       = rch_r;
    rattr_nxt     = rattr_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = cnt_r;
    mem_wr_data   = {fill_attr_r, CHAR_BLANK};
    mem_rd_addr   = AW'(idx_r);
    res_valid     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          chr_nxt   = in_data.character;
          idx_nxt   = in_data.cell_index;
          rch_nxt   = 8'd0;
          rattr_nxt = 8'd0;
          state_nxt = S_DONE;
          case (in_data.action)
            ACT_PUT: begin
              if (in_data.character != CHAR_NULL) begin
                if (past_end) begin
                  // Scroll first, then place the character.
                  cursor_nxt = cursor_r - CW'(COLUMNS);
                  cnt_nxt    = AW'(COLUMNS);
                  pv_nxt     = 1'b0;
                  ret_nxt    = S_PUT;
                  state_nxt  = S_COPY;
                end else begin
                  state_nxt = S_PUT;
                end
              end
            end
            ACT_NEWLINE: begin
              col_nxt = '0;
              if (row_next >= CW'(CELLS)) begin
                cursor_nxt = row_next - CW'(COLUMNS);
                cnt_nxt    = AW'(COLUMNS);
                pv_nxt     = 1'b0;
                ret_nxt    = S_DONE;
                state_nxt  = S_COPY;
              end else begin
                cursor_nxt = row_next;
              end
            end
            ACT_BACKSPACE: begin
              if (cursor_r != '0) begin
                cursor_nxt  = cursor_r - CW'(1);
                col_nxt     = (col_r == '0) ? COLW'(COLUMNS - 1) : col_r - COLW'(1);
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(cursor_r - CW'(1));
                mem_wr_data = {attr_r, CHAR_BLANK};
              end
            end
            ACT_CLEAR: begin
              cursor_nxt    = '0;
              col_nxt       = '0;
              cnt_nxt       = '0;
              fill_attr_nxt = attr_r;
              ret_nxt       = S_DONE;
              state_nxt     = S_FILL;
            end
            ACT_READ: begin
              if (32'(in_data.cell_index) < CELLS) begin
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Place one character or take the newline, cursor is inside the screen.
      S_PUT: begin
        state_nxt = S_DONE;
        if (chr_r == CHAR_NEWLINE) begin
          cursor_nxt = row_next;
          col_nxt    = '0;
        end else begin
          mem_wr_en   = (cursor_r < CW'(CELLS));
          mem_wr_addr = AW'(cursor_r);
          mem_wr_data = {attr_r, chr_r};
          cursor_nxt  = cursor_r + CW'(1);
          col_nxt     = (col_r == COLW'(COLUMNS - 1)) ? '0 : col_r + COLW'(1);
        end
      end

      // Move each cell up one row: read ahead, write the previous read.
      S_COPY: begin
        mem_rd_addr = cnt_r;
        mem_wr_en   = pv_r;
        mem_wr_addr = wa_r;
        mem_wr_data = mem_rd_data;
        wa_nxt      = cnt_r - AW'(COLUMNS);
        pv_nxt      = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      // Write the last copied cell, then blank the bottom row.
      S_DRAIN: begin
        mem_wr_en     = 1'b1;
        mem_wr_addr   = wa_r;
        mem_wr_data   = mem_rd_data;
        pv_nxt        = 1'b0;
        cnt_nxt       = AW'(CELLS - COLUMNS);
        fill_attr_nxt = attr_r;
        state_nxt     = S_FILL;
      end

      // Blank cells from the counter up to the last cell.
      S_FILL: begin
        mem_wr_en = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt = ret_r;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      S_READ: begin
        state_nxt = S_RDATA;
      end

      S_RDATA: begin
        rch_nxt   = mem_rd_data[7:0];
        rattr_nxt = mem_rd_data[15:8];
        state_nxt = S_DONE;
      end

      // Hand the result to the output register.
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the blanking pass over the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      ret_r       <= S_IDLE;
      cursor_r    <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      fill_attr_r <= ATTR_RESET;
      attr_r      <= ATTR_RESET;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      fill_attr_r <= fill_attr_nxt;
      attr_r      <= attr_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wa_r    <= wa_nxt;
    chr_r   <= chr_nxt;
    idx_r   <= idx_nxt;
    rch_r   <= rch_nxt;
    rattr_r <= rattr_nxt;
  end

  assign res_data.cursor_cell    = 11'(cursor_r);
  assign res_data.read_character = rch_r;
  assign res_data.read_attribute = rattr_r;

endmodule

### rtl/text_console_writer.sv
// Text console writer: put, newline, backspace, clear and read on a text screen.
// A scroll moves every row up one and blanks the bottom row, and clear blanks every cell,
// one cell at a time through the one write port of the store.
// One transaction at a time; a new one is taken while the last result waits.
// Synchronous reset runs a blanking pass over the whole store, input stalled.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tcw_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tcw_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic          res_valid;
  logic          res_take;
  tcw_out_t      res_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [15:0]   mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [15:0]   mem_rd_data;
  logic          out_valid_r;
  tcw_out_t      out_data_r;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register takes a result when empty or being drained.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer.
// Depends on tcw_pkg for the transaction structs and codes, and on the text_console_writer RTL.
`timescale 1ns / 100ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;

  // Action codes the block does not define; they must leave the screen alone.
  localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
  localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

  localparam logic [10:0] LAST_CELL = 11'(CELLS - 1);
  localparam logic [10:0] LAST_ROW_START = 11'(CELLS - COLUMNS);
  localparam logic [10:0] INDEX_ALL_ONES = '1;

  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PRESSURE_PHASE = 2;
  localparam int QUIET_PHASE = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS = 200;

  typedef enum {MODE_TEXT, MODE_LONG, MODE_NOISE} traffic_mode_t;

  typedef struct {
    tcw_in_t     item;
    int unsigned repeat_count;
    bit          typed;
    tcw_out_t    result;
  } script_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  tcw_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  tcw_out_t   out_data;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  // Typed-in expectation that travels alongside each input transaction.
  logic     check_typed;
  tcw_out_t typed_expect;

  // Shadow copy of the screen, cursor and attribute register.
  logic [15:0] screen_model [CELLS];
  int unsigned cursor_model;
  logic [7:0]  attr_model;

  tcw_out_t expected_results [$];
  script_row_t directed_rows [19];

  int items_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_request = 1'b0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fill every cell with a space in the current attribute.
  function automatic void blank_screen();
    for (int c = 0; c < CELLS; c++) screen_model[c] = {attr_model, CHAR_BLANK};
  endfunction

  // Move all rows up by one, blank the bottom row and pull the cursor up a row.
  function automatic void scroll_screen();
    for (int c = 0; c < CELLS - COLUMNS; c++) screen_model[c] = screen_model[c + COLUMNS];
    for (int c = CELLS - COLUMNS; c < CELLS; c++) screen_model[c] = {attr_model, CHAR_BLANK};
    cursor_model = (cursor_model >= COLUMNS) ? cursor_model - COLUMNS : 0;
  endfunction

  function automatic int unsigned next_row_start(int unsigned pos);
    return (pos / COLUMNS + 1) * COLUMNS;
  endfunction

  // Apply one action to the shadow console and return the result it produces.
  function automatic tcw_out_t console_step(tcw_in_t cmd);
    tcw_out_t res;
    res = '0;
    case (cmd.action)
      ACT_PUT: begin
        if (cmd.character != CHAR_NULL) begin
          if (cursor_model >= CELLS) scroll_screen();
          if (cmd.character == CHAR_NEWLINE) begin
            cursor_model = next_row_start(cursor_model);
          end else begin
            if (cursor_model < CELLS) screen_model[cursor_model] = {attr_model, cmd.character};
            cursor_model++;
          end
        end
      end
      ACT_NEWLINE: begin
        cursor_model = next_row_start(cursor_model);
        if (cursor_model >= CELLS) scroll_screen();
      end
      ACT_BACKSPACE: begin
        if (cursor_model > 0) begin
          cursor_model--;
          screen_model[cursor_model] = {attr_model, CHAR_BLANK};
        end
      end
      ACT_CLEAR: begin
        blank_screen();
        cursor_model = 0;
      end
      ACT_READ: begin
        if (cmd.cell_index < CELLS) begin
          res.read_character = screen_model[cmd.cell_index][7:0];
          res.read_attribute = screen_model[cmd.cell_index][15:8];
        end
      end
      default: begin
      end
    endcase
    res.cursor_cell = 11'(cursor_model);
    return res;
  endfunction

  // Draw a random input transaction shaped by the traffic mode.
  function automatic tcw_in_t random_item(traffic_mode_t mode);
    tcw_in_t item;
    int unsigned pick;
    item.action = ACT_PUT;
    item.character = 8'($urandom_range(1, 255));
    item.cell_index = 11'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    case (mode)
      MODE_TEXT: begin
        // Short lines of text with frequent line breaks and edits.
        if (pick < 3) item.character = CHAR_NEWLINE;
        else if (pick < 4) item.character = CHAR_NULL;
        else if (pick < 68) item.action = ACT_PUT;
        else if (pick < 74) item.action = ACT_NEWLINE;
        else if (pick < 80) item.action = ACT_BACKSPACE;
        else item.action = ACT_READ;
      end
      MODE_LONG: begin
        // Long runs of characters that wrap rows and run off the bottom.
        if (pick < 1) item.action = ACT_NEWLINE;
        else if (pick < 4) item.action = ACT_BACKSPACE;
        else if (pick < 88) item.action = ACT_PUT;
        else item.action = ACT_READ;
      end
      default: begin
        // Anything at all, with clears kept rare so the screen stays busy.
        item.action = 3'($urandom_range(ACT_PUT, ACT_RESERVED_HI));
        item.character = 8'($urandom_range(0, 255));
        if (item.action == ACT_CLEAR && $urandom_range(0, 9) != 0) item.action = ACT_PUT;
      end
    endcase
    // Most reads target the top rows or the bottom rows where text lives.
    if (item.action == ACT_READ && $urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1) != 0) item.cell_index = 11'($urandom_range(0, 2 * COLUMNS - 1));
      else item.cell_index = 11'($urandom_range(CELLS - 4 * COLUMNS, CELLS - 1));
    end
    return item;
  endfunction

  // Offer one input transaction and hold it until the block takes it.
  task automatic send_item(tcw_in_t item, bit typed, tcw_out_t result);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    check_typed <= typed;
    typed_expect <= result;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every result transaction has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  task automatic check_field(string name, logic [10:0] want, logic [10:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int unsigned burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Track register writes, predict accepted inputs and check accepted results.
  always @(posedge clk) begin : scoreboard
    tcw_out_t want;
    tcw_out_t predicted;
    if (rst_n) begin
      if (cfg_wr_en) attr_model = cfg_wr_data;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $error("result transaction with none expected: cursor_cell %0d",
                   out_data.cursor_cell);
        end else begin
          want = expected_results.pop_front();
          check_field("cursor_cell", want.cursor_cell, out_data.cursor_cell);
          check_field("read_character", want.read_character, out_data.read_character);
          check_field("read_attribute", want.read_attribute, out_data.read_attribute);
        end
      end
      if (in_valid && !in_stall) begin
        predicted = console_step(in_data);
        expected_results.push_back(check_typed ? typed_expect : predicted);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // End the run if the handshakes stop moving for too long.
  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_text_console_writer NOT OK");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int counted;
    tcw_in_t item;
    traffic_mode_t mode;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    check_typed <= 1'b0;
    typed_expect <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    attr_model = ATTR_RESET;
    blank_screen();
    cursor_model = 0;

    // Directed transactions: reset state, field extremes and every special case.
    directed_rows = '{
      '{{ACT_READ, CHAR_NULL, 11'd0}, 1, 1'b1, {11'd0, CHAR_BLANK, ATTR_RESET}},
      '{{ACT_READ, CHAR_NULL, LAST_CELL}, 1, 1'b1, {11'd0, CHAR_BLANK, ATTR_RESET}},
      // A read past the screen returns zeros.
      '{{ACT_READ, CHAR_NULL, INDEX_ALL_ONES}, 1, 1'b1, '0},
      // Backspace at the origin, the null character and spare codes change nothing.
      '{{ACT_BACKSPACE, CHAR_NULL, 11'd0}, 1, 1'b1, '0},
      '{{ACT_PUT, CHAR_NULL, 11'd0}, 1, 1'b1, '0},
      '{{ACT_RESERVED_HI, 8'hFF, INDEX_ALL_ONES}, 1, 1'b1, '0},
      '{{ACT_PUT, 8'hFF, 11'd0}, 1, 1'b1, {11'd1, CHAR_NULL, 8'h00}},
      '{{ACT_READ, CHAR_NULL, 11'd0}, 1, 1'b1, {11'd1, 8'hFF, ATTR_RESET}},
      '{{ACT_RESERVED_LO, CHAR_NULL, 11'd0}, 1, 1'b1, {11'd1, CHAR_NULL, 8'h00}},
      '{{ACT_BACKSPACE, CHAR_NULL, 11'd0}, 1, 1'b1, '0},
      '{{ACT_READ, CHAR_NULL, 11'd0}, 1, 1'b1, {11'd0, CHAR_BLANK, ATTR_RESET}},
      // Step down to the last row, then scroll by newline, past the end and by put.
      '{{ACT_PUT, CHAR_NEWLINE, 11'd0}, ROWS - 1, 1'b0, '0},
      '{{ACT_NEWLINE, CHAR_NULL, 11'd0}, 1, 1'b0, '0},
      '{{ACT_PUT, CHAR_NEWLINE, 11'd0}, 1, 1'b0, '0},
      '{{ACT_NEWLINE, CHAR_NULL, 11'd0}, 1, 1'b0, '0},
      '{{ACT_PUT, 8'h41, 11'd0}, 1, 1'b0, '0},
      '{{ACT_READ, CHAR_NULL, LAST_ROW_START}, 1, 1'b0, '0},
      '{{ACT_CLEAR, CHAR_NULL, 11'd0}, 1, 1'b1, '0},
      '{{ACT_READ, CHAR_NULL, LAST_ROW_START}, 1, 1'b1, {11'd0, CHAR_BLANK, ATTR_RESET}}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].repeat_count; n++)
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);
    end

    // Random phases; the attribute changes only once the block has drained.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      if (phase > 0) begin
        cfg_wr_en <= 1'b1;
        if (phase == 1) cfg_wr_data <= 8'h00;
        else if (phase == 2) cfg_wr_data <= 8'hFF;
        else cfg_wr_data <= 8'($urandom_range(0, 255));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end
      if (phase % 4 == 3) mode = MODE_NOISE;
      else if (phase % 2 == 1) mode = MODE_LONG;
      else mode = MODE_TEXT;
      tx_idle_on = (phase != QUIET_PHASE && phase != PRESSURE_PHASE && phase != PHASES - 1);
      rx_idle_on = (phase != QUIET_PHASE && phase != PHASES - 1);
      // The receiver holds off while inputs keep coming, so the block backs up.
      if (phase == PRESSURE_PHASE) hold_request = 1'b1;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        item = random_item(mode);
        send_item(item, 1'b0, '0);
        counted++;
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $error("%0d expected result transactions never arrived", expected_results.size());
    end

    if (error_count == 0) begin
      $display("tb_text_console_writer OK");
    end else begin
      $display("tb_text_console_writer NOT OK");
    end
    $finish;
  end

endmodule
